/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check.
`define FFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent holds, consequent follows in the next cycle.
`define FFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffp_pkg.sv */
package ffp_pkg;

  localparam int BAD_COUNT_BITS = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] CFG_HEADER = 2'd0;
  localparam logic [1:0] CFG_ADDR   = 2'd1;
  localparam logic [1:0] CFG_CMD    = 2'd2;

  localparam logic [2:0] POS_ADDR   = 3'd1;
  localparam logic [2:0] POS_CMD    = 3'd2;
  localparam logic [2:0] POS_ID     = 3'd3;
  localparam logic [2:0] POS_VAL_LO = 3'd4;
  localparam logic [2:0] POS_VAL_HI = 3'd5;
  localparam logic [2:0] POS_CRC_HI = 3'd6;
  localparam logic [2:0] POS_CRC_LO = 3'd7;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] addr;
    logic [7:0] cmd;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  param_id;
    logic [15:0] param_value;
    logic [31:0] bad_frames;
  } result_t;

  // one byte of reflected CRC-16/Modbus
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/fixed_frame_parser_crc16_modbus_unit.sv */
// Fixed 8-byte frame parser with CRC-16/Modbus check.
// Throughput: one byte item per cycle while in_stall is low; the CRC advances one byte per cycle.
// Result: registered into the output entry, or into the skid entry when the output is stalled.
// Two-entry output buffer; in_stall rises only when both entries are full.
// rst (sync, high): config to 0xA5/0x01/0x21, parser hunting, counters zero.
`include "assert_macros.svh"

module fixed_frame_parser_crc16_modbus_unit import ffp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  param_id,
  output logic [15:0] param_value,
  output logic [31:0] bad_frames
);

  cfg_t    cfg;
  logic    acc;
  result_t core_res;
  result_t out_res;

  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header <= 8'hA5;
      cfg.addr   <= 8'h01;
      cfg.cmd    <= 8'h21;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER: cfg.header <= cfg_data;
        CFG_ADDR:   cfg.addr   <= cfg_data;
        CFG_CMD:    cfg.cmd    <= cfg_data;
        default: ;
      endcase
    end
  end

  ffp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (core_res)
  );

  ffp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_en     (acc),
    .in_res    (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (in_stall)
  );

  assign status      = out_res.status;
  assign param_id    = out_res.param_id;
  assign param_value = out_res.param_value;
  assign bad_frames  = out_res.bad_frames;

  `FFP_ASSERT(a_stall_needs_out, !in_stall || out_valid, "input stalled with empty output")
  `FFP_ASSERT_NEXT(a_acc_gives_out, in_valid && !in_stall, out_valid, "accepted item lost")
  `FFP_ASSERT_NEXT(a_drain_frees, out_valid && !out_stall, !in_stall, "buffer not freed")

endmodule

/* rtl/ffp_core.sv */
module ffp_core import ffp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic                      hunting, hunting_next;
  logic [2:0]                byte_index, byte_index_next;
  logic [15:0]               crc, crc_next;
  logic [7:0]                b_addr, b_cmd, b_id, b_vlo, b_vhi, b_crc_hi;
  logic [7:0]                last_id, last_id_next;
  logic [15:0]               last_value, last_value_next;
  logic [BAD_COUNT_BITS-1:0] bad_count, bad_count_next;
  logic [1:0]                status;
  logic                      is_header;
  logic                      frame_ok;
  logic [15:0]               crc_start;

  assign is_header = (rx_byte == cfg.header);
  assign crc_start = crc16_byte(CRC_INIT, rx_byte);
  assign frame_ok  = (b_addr == cfg.addr) && (b_cmd == cfg.cmd) &&
                     (crc == {b_crc_hi, rx_byte});

  always_comb begin
    hunting_next    = hunting;
    byte_index_next = byte_index;
    crc_next        = crc;
    last_id_next    = last_id;
    last_value_next = last_value;
    bad_count_next  = bad_count;
    status          = ST_NONE;
    if (hunting) begin
      if (is_header) begin
        crc_next        = crc_start;
        byte_index_next = POS_ADDR;
        hunting_next    = 1'b0;
      end
    end else begin
      if (byte_index <= POS_VAL_HI) begin
        crc_next = crc16_byte(crc, rx_byte);
      end
      if (byte_index != POS_CRC_LO) begin
        byte_index_next = byte_index + 3'd1;
      end else begin
        if (frame_ok) begin
          last_id_next    = b_id;
          last_value_next = {b_vhi, b_vlo};
          status          = ST_GOOD;
        end else begin
          bad_count_next = bad_count + 1'b1;
          status         = ST_BAD;
        end
        if (is_header) begin
          crc_next        = crc_start;
          byte_index_next = POS_ADDR;
          hunting_next    = 1'b0;
        end else begin
          byte_index_next = 3'd0;
          hunting_next    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting    <= 1'b1;
      byte_index <= 3'd0;
      last_id    <= 8'd0;
      last_value <= 16'd0;
      bad_count  <= '0;
    end else if (acc) begin
      hunting    <= hunting_next;
      byte_index <= byte_index_next;
      last_id    <= last_id_next;
      last_value <= last_value_next;
      bad_count  <= bad_count_next;
    end
  end

  // frame bytes, no reset needed
  always_ff @(posedge clk) begin
    if (acc) begin
      crc <= crc_next;
      if (!hunting) begin
        unique case (byte_index)
          POS_ADDR:   b_addr   <= rx_byte;
          POS_CMD:    b_cmd    <= rx_byte;
          POS_ID:     b_id     <= rx_byte;
          POS_VAL_LO: b_vlo    <= rx_byte;
          POS_VAL_HI: b_vhi    <= rx_byte;
          POS_CRC_HI: b_crc_hi <= rx_byte;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res.status      = status;
    res.param_id    = last_id_next;
    res.param_value = last_value_next;
    res.bad_frames  = 32'(bad_count_next);
  end

endmodule

/* rtl/ffp_skid.sv */
module ffp_skid import ffp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_en,
  input  result_t in_res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res,
  output logic    full
);

  logic    skid_valid;
  result_t skid_res;
  logic    out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_en) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (in_en) begin
      if (!out_valid || out_fire) begin
        out_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end
  end

endmodule
